[rtl/fpba_pkg.sv]
// fpba_pkg: shared constants, codes and types of the fit-policy block allocator
// used by every rtl file of the block but fpba_ram; no dependencies
`default_nettype none

package fpba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    // field widths of the stream and register items
    localparam int OP_W     = 1;
    localparam int SLOT_W   = 4;
    localparam int AMT_W    = 16;
    localparam int CHOSEN_W = 4;
    localparam int LEFT_W   = 16;
    localparam int MODE_W   = 2;
    localparam int BIU_W    = 5;
    localparam int LIM_W    = (CNT_W > BIU_W) ? CNT_W : BIU_W;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_REQ  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic REG_FIT_MODE = 1'b0;
    localparam logic REG_BLOCKS   = 1'b1;

    localparam logic [MODE_W-1:0] FIT_MODE_RST = MODE_FIRST;
    localparam logic [BIU_W-1:0]  BLOCKS_RST   = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                 we;
        logic [IDX_W-1:0]     waddr;
        logic [SIZE_BITS-1:0] wdata;
        logic [IDX_W-1:0]     raddr;
    } t_ram_req;

    typedef struct packed {
        logic fit;
        logic lower;
        logic higher;
    } t_cmp;

endpackage

`default_nettype wire

[rtl/fpba_ram.sv]
// fpba_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/fpba_alu.sv]
// fpba_alu: shared compare and subtract unit of the allocator scan
// depends on fpba_pkg
`default_nettype none

module fpba_alu (
    input  wire logic [fpba_pkg::SIZE_BITS-1:0] i_entry,
    input  wire logic [fpba_pkg::SIZE_BITS-1:0] i_amt,
    input  wire logic [fpba_pkg::SIZE_BITS-1:0] i_best,
    output fpba_pkg::t_cmp                      o_cmp,
    output logic      [fpba_pkg::SIZE_BITS-1:0] o_diff
);
    import fpba_pkg::*;

    always_comb begin
        o_cmp.fit    = (i_entry >= i_amt);
        o_cmp.lower  = (i_entry < i_best);
        o_cmp.higher = (i_entry > i_best);
        o_diff       = i_best - i_amt;
    end

endmodule

`default_nettype wire

[rtl/fpba_seq.sv]
// fpba_seq: scan sequencer, pick and best-capacity registers and result register
// depends on fpba_pkg and fpba_alu
`default_nettype none

module fpba_seq (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [fpba_pkg::MODE_W-1:0]    i_fit_mode,
    input  wire logic [fpba_pkg::BIU_W-1:0]     i_blocks_in_use,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [fpba_pkg::OP_W-1:0]      i_operation,
    input  wire logic [fpba_pkg::SLOT_W-1:0]    i_block_slot,
    input  wire logic [fpba_pkg::AMT_W-1:0]     i_amount,
    output fpba_pkg::t_ram_req                  o_ram,
    input  wire logic [fpba_pkg::SIZE_BITS-1:0] i_ram_q,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_granted,
    output logic      [fpba_pkg::CHOSEN_W-1:0]  o_chosen_block,
    output logic      [fpba_pkg::LEFT_W-1:0]    o_capacity_left
);
    import fpba_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_chk_vld;
    logic [IDX_W-1:0]     r_chk_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_best;
    logic [SIZE_BITS-1:0] r_amt;
    logic                 r_out_vld;
    logic                 r_out_grant;
    logic [CHOSEN_W-1:0]  r_out_blk;
    logic [LEFT_W-1:0]    r_out_left;

    t_cmp                 cmp;
    logic [SIZE_BITS-1:0] diff;
    logic [CNT_W-1:0]     limit;
    logic                 first_only;
    logic                 stop;
    logic                 issue;
    logic                 take;
    logic                 scan_done;
    logic                 out_free;
    logic                 accept;
    logic                 load_ok;

    fpba_alu u_alu (
        .i_entry (i_ram_q),
        .i_amt   (r_amt),
        .i_best  (r_best),
        .o_cmp   (cmp),
        .o_diff  (diff)
    );

    // scan length saturates at the table depth
    always_comb begin
        if (LIM_W'(i_blocks_in_use) > LIM_W'(NUM_BLOCKS)) begin
            limit = CNT_W'(NUM_BLOCKS);
        end else begin
            limit = CNT_W'(i_blocks_in_use);
        end
    end

    always_comb begin
        first_only = !((i_fit_mode == MODE_BEST) || (i_fit_mode == MODE_WORST));
        stop       = first_only && r_found;
        issue      = (r_state == ST_SCAN) && (r_idx < limit) && !stop;
        take       = r_chk_vld && !stop && cmp.fit &&
                     (!r_found || ((i_fit_mode == MODE_BEST) && cmp.lower) ||
                      ((i_fit_mode == MODE_WORST) && cmp.higher));
        scan_done  = (r_state == ST_SCAN) && !r_chk_vld && ((r_idx >= limit) || stop);
        out_free   = !r_out_vld || i_out_ready;
        accept     = (r_state == ST_IDLE) && i_in_valid;
        load_ok    = (CNT_W'(i_block_slot) < CNT_W'(NUM_BLOCKS));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_operation == OP_REQ)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and table port
    always_comb begin
        o_in_ready  = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = IDX_W'(i_block_slot);
        o_ram.wdata = SIZE_BITS'(i_amount);
        o_ram.raddr = r_idx[IDX_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ram.we   = accept && (i_operation == OP_LOAD) && load_ok;
            end
            ST_SCAN: begin
                o_ram.we = 1'b0;
            end
            ST_FIN: begin
                o_ram.we    = out_free && r_found;
                o_ram.waddr = r_pick;
                o_ram.wdata = diff;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_chk_vld <= 1'b0;
            r_found   <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_idx     <= '0;
                r_chk_vld <= 1'b0;
                r_found   <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_chk_vld <= issue;
                if (issue) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_amt <= SIZE_BITS'(i_amount);
        end
        if (issue) begin
            r_chk_idx <= r_idx[IDX_W-1:0];
        end
        if (take) begin
            r_pick <= r_chk_idx;
            r_best <= i_ram_q;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && out_free) begin
            r_out_grant <= r_found;
            r_out_blk   <= r_found ? CHOSEN_W'(r_pick) : '0;
            r_out_left  <= r_found ? LEFT_W'(diff) : '0;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_granted       = r_out_grant;
    assign o_chosen_block  = r_out_blk;
    assign o_capacity_left = r_out_left;

endmodule

`default_nettype wire

[rtl/fit_policy_block_allocator_unit.sv]
// fit_policy_block_allocator_unit: top level with config registers, capacity table and sequencer
// depends on fpba_pkg, fpba_ram, fpba_alu and fpba_seq
// a load is written to the table as its beat is taken; a request reads one table entry per
// cycle through the single read port, scanning up to blocks_in_use entries (at most 16), and
// takes the next beat only after its result is registered; first fit ends at the first block that fits
// reset clears control and sets fit_mode 0, blocks_in_use 16; table contents stay
// undefined until loaded, with no clearing pass
`default_nettype none

module fit_policy_block_allocator_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fpba_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fpba_pkg::PDATA_W-1:0]  pwdata,
    output logic      [fpba_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [fpba_pkg::S_TDATA_W-1:0] s_tdata,  // block_slot, amount
    input  wire logic [fpba_pkg::OP_W-1:0]     s_tuser,   // operation
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [fpba_pkg::M_TDATA_W-1:0] m_tdata,  // chosen_block, capacity_left
    output logic                               m_tuser    // granted
);
    import fpba_pkg::*;

    logic [MODE_W-1:0]    r_fit_mode;
    logic [BIU_W-1:0]     r_blocks_in_use;
    t_ram_req             ram_req;
    logic [SIZE_BITS-1:0] ram_q;
    logic                 cfg_wr;
    logic [CHOSEN_W-1:0]  chosen_block;
    logic [LEFT_W-1:0]    capacity_left;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode      <= FIT_MODE_RST;
            r_blocks_in_use <= BLOCKS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FIT_MODE: r_fit_mode      <= pwdata[MODE_W-1:0];
                REG_BLOCKS:   r_blocks_in_use <= pwdata[BIU_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FIT_MODE: prdata = PDATA_W'(r_fit_mode);
            REG_BLOCKS:   prdata = PDATA_W'(r_blocks_in_use);
            default:      prdata = '0;
        endcase
    end

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_q)
    );

    fpba_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fit_mode      (r_fit_mode),
        .i_blocks_in_use (r_blocks_in_use),
        .i_in_valid      (s_tvalid),
        .o_in_ready      (s_tready),
        .i_operation     (s_tuser),
        .i_block_slot    (s_tdata[SLOT_W-1:0]),
        .i_amount        (s_tdata[SLOT_W+AMT_W-1:SLOT_W]),
        .o_ram           (ram_req),
        .i_ram_q         (ram_q),
        .o_out_valid     (m_tvalid),
        .i_out_ready     (m_tready),
        .o_granted       (m_tuser),
        .o_chosen_block  (chosen_block),
        .o_capacity_left (capacity_left)
    );

    assign m_tdata = {{(M_TDATA_W-CHOSEN_W-LEFT_W){1'b0}}, capacity_left, chosen_block};

    // a refused request reports all zeros
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("refused request with non-zero result");

    // a request keeps the input side closed while it scans
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_REQ)) |=> !s_tready)
        else $error("input taken during a request scan");

    // a load beat never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_LOAD) && !m_tvalid) |=> !m_tvalid)
        else $error("result after a load beat");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// tb_top: self-checking testbench for fit_policy_block_allocator_unit
// runs a directed table, then random phases, each checked against a built-in allocation predictor
// depends on fpba_pkg and the rtl of the block
module tb_top;
    import fpba_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 127;

    typedef struct packed {
        logic                granted;
        logic [CHOSEN_W-1:0] chosen;
        logic [LEFT_W-1:0]   left;
    } t_grant;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_MODE,
        ROW_BLOCKS
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [AMT_W-1:0]  amt;
        logic              typed;
        t_grant            want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;  // block_slot, amount
    logic [OP_W-1:0]      s_tuser;  // operation
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;  // chosen_block, capacity_left
    logic                 m_tuser;  // granted

    logic [SIZE_BITS-1:0] cap_tbl [NUM_BLOCKS];
    logic [MODE_W-1:0]    cur_mode;
    logic [BIU_W-1:0]     cur_blocks;
    t_grant               grant_q [$];
    t_row                 steps [$];
    int                   fail_cnt = 0;
    int                   stall_left;
    bit                   tx_quiet;
    bit                   rx_quiet;

    fit_policy_block_allocator_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("[fit_policy_block_allocator_unit] ERROR");
        $finish;
    end

    function automatic void add_row(input t_row row);
        steps.insert(steps.size(), row);
    endfunction

    function automatic t_grant allocate(input logic [AMT_W-1:0] size);
        t_grant res;
        int     lim;
        int     pick;
        bit     found;
        bit     done;
        res   = '0;
        pick  = 0;
        found = 1'b0;
        done  = 1'b0;
        lim   = (cur_blocks > NUM_BLOCKS) ? NUM_BLOCKS : int'(cur_blocks);
        for (int j = 0; j < NUM_BLOCKS; j++) begin
            if (j < lim && !done && cap_tbl[j] >= size) begin
                if (!found) begin
                    found = 1'b1;
                    pick  = j;
                    done  = (cur_mode != MODE_BEST && cur_mode != MODE_WORST);
                end else if (cur_mode == MODE_BEST && cap_tbl[j] < cap_tbl[pick]) begin
                    pick = j;
                end else if (cur_mode == MODE_WORST && cap_tbl[j] > cap_tbl[pick]) begin
                    pick = j;
                end
            end
        end
        if (found) begin
            cap_tbl[pick] = cap_tbl[pick] - size;
            res.granted   = 1'b1;
            res.chosen    = pick[CHOSEN_W-1:0];
            res.left      = cap_tbl[pick];
        end
        return res;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                             input logic [AMT_W-1:0] amt, input bit typed, input t_grant want);
        int     gap;
        t_grant res;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, amt, slot};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (op == OP_LOAD) begin
            cap_tbl[slot] = amt;
        end else begin
            res = allocate(amt);
            grant_q.insert(grant_q.size(), typed ? want : res);
        end
    endtask

    task automatic drain_grants();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (grant_q.size() != 0);
    endtask

    // loads leave no result, so give the block time to finish before touching registers
    task automatic wait_idle();
        drain_grants();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FIT_MODE)
            cur_mode = val[MODE_W-1:0];
        else
            cur_blocks = val[BIU_W-1:0];
    endtask

    always @(posedge i_clk) begin : result_side
        t_grant got;
        t_grant want;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[CHOSEN_W-1:0], m_tdata[CHOSEN_W+LEFT_W-1:CHOSEN_W]};
                if (grant_q.size() == 0) begin
                    $error("unexpected result beat: granted %0d chosen_block %0d left %0d",
                           got.granted, got.chosen, got.left);
                    fail_cnt++;
                end else begin
                    want = grant_q.pop_front();
                    if (got.granted !== want.granted) begin
                        $error("granted: expected %0d, got %0d", want.granted, got.granted);
                        fail_cnt++;
                    end
                    if (got.chosen !== want.chosen) begin
                        $error("chosen_block: expected %0d, got %0d", want.chosen, got.chosen);
                        fail_cnt++;
                    end
                    if (got.left !== want.left) begin
                        $error("capacity_left: expected %0d, got %0d", want.left, got.left);
                        fail_cnt++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    rx_quiet = !rx_quiet;
                stall_left = rx_quiet ? 0 : $urandom_range(0, 12);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [AMT_W-1:0]  amt;
        logic [BIU_W-1:0]  blocks;
        int                pick;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_LOAD;
        tx_quiet   = 1'b0;
        cur_mode   = FIT_MODE_RST;
        cur_blocks = BLOCKS_RST;

        // single block: full size, zero size on an empty block, no fit
        add_row('{ROW_BLOCKS, OP_LOAD, 4'd0, 16'd1, 1'b0, '0});
        add_row('{ROW_ITEM, OP_LOAD, 4'd0, 16'hFFFF, 1'b0, '0});
        add_row('{ROW_ITEM, OP_REQ, 4'd0, 16'hFFFF, 1'b1, '{1'b1, 4'd0, 16'd0}});
        add_row('{ROW_ITEM, OP_REQ, 4'd9, 16'd0, 1'b1, '{1'b1, 4'd0, 16'd0}});
        add_row('{ROW_ITEM, OP_REQ, 4'd0, 16'd1, 1'b1, '{1'b0, 4'd0, 16'd0}});
        // empty scan grants nothing
        add_row('{ROW_BLOCKS, OP_LOAD, 4'd0, 16'd0, 1'b0, '0});
        add_row('{ROW_ITEM, OP_REQ, 4'd0, 16'd0, 1'b1, '{1'b0, 4'd0, 16'd0}});
        // four blocks through every fit mode
        add_row('{ROW_BLOCKS, OP_LOAD, 4'd0, 16'd4, 1'b0, '0});
        add_row('{ROW_ITEM, OP_LOAD, 4'd1, 16'd100, 1'b0, '0});
        add_row('{ROW_ITEM, OP_LOAD, 4'd2, 16'd50, 1'b0, '0});
        add_row('{ROW_ITEM, OP_LOAD, 4'd3, 16'd200, 1'b0, '0});
        add_row('{ROW_ITEM, OP_LOAD, 4'd0, 16'd150, 1'b0, '0});
        add_row('{ROW_ITEM, OP_REQ, 4'd0, 16'd60, 1'b0, '0});
        add_row('{ROW_MODE, OP_LOAD, 4'd0, {14'd0, MODE_BEST}, 1'b0, '0});
        add_row('{ROW_ITEM, OP_REQ, 4'd0, 16'd60, 1'b0, '0});
        add_row('{ROW_MODE, OP_LOAD, 4'd0, {14'd0, MODE_WORST}, 1'b0, '0});
        add_row('{ROW_ITEM, OP_REQ, 4'd0, 16'd60, 1'b0, '0});
        add_row('{ROW_MODE, OP_LOAD, 4'd0, {14'd0, MODE_SPARE}, 1'b0, '0});
        add_row('{ROW_ITEM, OP_REQ, 4'd0, 16'd60, 1'b0, '0});
        add_row('{ROW_ITEM, OP_LOAD, 4'd15, 16'hAAAA, 1'b0, '0});
        add_row('{ROW_ITEM, OP_LOAD, 4'd10, 16'h5555, 1'b0, '0});
        // ties go to the lower index
        add_row('{ROW_MODE, OP_LOAD, 4'd0, {14'd0, MODE_BEST}, 1'b0, '0});
        add_row('{ROW_ITEM, OP_LOAD, 4'd2, 16'd40, 1'b0, '0});
        add_row('{ROW_ITEM, OP_REQ, 4'd0, 16'd40, 1'b0, '0});
        add_row('{ROW_MODE, OP_LOAD, 4'd0, {14'd0, MODE_WORST}, 1'b0, '0});
        add_row('{ROW_ITEM, OP_LOAD, 4'd0, 16'd140, 1'b0, '0});
        add_row('{ROW_ITEM, OP_REQ, 4'd0, 16'd10, 1'b0, '0});
        add_row('{ROW_ITEM, OP_REQ, 4'd0, 16'd0, 1'b0, '0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[i]) begin
            case (steps[i].kind)
                ROW_ITEM: begin
                    send_item(steps[i].op, steps[i].slot, steps[i].amt, steps[i].typed,
                              steps[i].want);
                end
                ROW_MODE: begin
                    wait_idle();
                    apb_write(REG_FIT_MODE, {16'd0, steps[i].amt});
                end
                default: begin
                    wait_idle();
                    apb_write(REG_BLOCKS, {16'd0, steps[i].amt});
                end
            endcase
        end

        // fill the whole table so any scan length is legal from here on
        for (int s = 0; s < NUM_BLOCKS; s++)
            send_item(OP_LOAD, s[SLOT_W-1:0], AMT_W'($urandom_range(200, 8000)), 1'b0, '0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                2:       blocks = 5'd31;
                3:       blocks = 5'd0;
                4:       blocks = 5'd1;
                6:       blocks = 5'd17;
                7:       blocks = BIU_W'($urandom_range(0, 31));
                default: blocks = 5'd16;
            endcase
            wait_idle();
            apb_write(REG_FIT_MODE, p % 4);
            apb_write(REG_BLOCKS, {27'd0, blocks});
            tx_quiet = (p % 3 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 19);
                slot = SLOT_W'($urandom_range(0, NUM_BLOCKS - 1));
                if ($urandom_range(0, 99) < 35) begin
                    op = OP_LOAD;
                    if (pick < 12)
                        amt = AMT_W'($urandom_range(200, 8000));
                    else if (pick < 18)
                        amt = AMT_W'($urandom);
                    else if (pick == 18)
                        amt = '0;
                    else
                        amt = '1;
                end else begin
                    op = OP_REQ;
                    if (pick < 14)
                        amt = AMT_W'($urandom_range(1, 600));
                    else if (pick < 16)
                        amt = '0;
                    else if (pick < 18)
                        amt = AMT_W'($urandom);
                    else
                        amt = AMT_W'($urandom_range(0, 4000));
                end
                send_item(op, slot, amt, 1'b0, '0);
                if ($urandom_range(0, 63) == 0)
                    drain_grants();
            end
        end

        drain_grants();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("[fit_policy_block_allocator_unit] OK");
        else
            $display("[fit_policy_block_allocator_unit] ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/fpba_pkg.sv
rtl/fpba_ram.sv
rtl/fpba_alu.sv
rtl/fpba_seq.sv
rtl/fit_policy_block_allocator_unit.sv
sim/tb_top.sv
